// File: hdl/dpms_pkg.sv
// Shared constants and types for the debounced priority mode select block.
`default_nettype none
package dpms_pkg;

  // Configuration register width and index width
  localparam int CFG_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 3;

  // Default tick counter width
  localparam int COUNT_WIDTH_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CW_CONFIRM = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CW_RELEASE = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OB_CONFIRM = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OB_RELEASE = 3'd3;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] CW_CONFIRM_RST = 16'd9;
  localparam logic [CFG_WIDTH-1:0] CW_RELEASE_RST = 16'd9;
  localparam logic [CFG_WIDTH-1:0] OB_CONFIRM_RST = 16'd6;
  localparam logic [CFG_WIDTH-1:0] OB_RELEASE_RST = 16'd15;

  // Drive mode codes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LANE      = 2'd0;
  localparam mode_t MODE_CROSSWALK = 2'd1;
  localparam mode_t MODE_LIGHT     = 2'd2;
  localparam mode_t MODE_OBSTACLE  = 2'd3;

  // Per-tick control into one qualifier channel
  typedef struct packed {
    logic step;  // a tick is transferred this cycle
    logic seen;  // sampled detector flag
  } chan_ctl_t;

endpackage
`default_nettype wire

// File: hdl/dpms_chan.sv
// On/off delay qualifier for one detector channel.
`default_nettype none
module dpms_chan #(
  parameter int COUNT_WIDTH = dpms_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire dpms_pkg::chan_ctl_t            ctl,
  input  wire logic [dpms_pkg::CFG_WIDTH-1:0] cfm_ticks,
  input  wire logic [dpms_pkg::CFG_WIDTH-1:0] rel_ticks,
  output logic                                qualified_nxt
);
  import dpms_pkg::*;

  // Compare width covers both counter and threshold ranges
  localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic                   run_r, run_nxt;
  logic                   ever_r, ever_nxt;
  logic                   qual_r;
  logic [COUNT_WIDTH-1:0] on_r, on_nxt;
  logic [COUNT_WIDTH-1:0] off_r, off_nxt;
  logic [COUNT_WIDTH-1:0] on_inc, off_inc;

  // Saturating increments
  assign on_inc  = (on_r == CNT_MAX) ? on_r : on_r + CNT_ONE;
  assign off_inc = (off_r == CNT_MAX) ? off_r : off_r + CNT_ONE;

  // Next state for one tick
  always_comb begin
    run_nxt       = run_r;
    ever_nxt      = ever_r;
    qualified_nxt = qual_r;
    on_nxt        = run_r ? on_inc : on_r;
    off_nxt       = off_r;
    if (ctl.seen) begin
      if (!run_r) begin
        run_nxt = 1'b1;
        on_nxt  = '0;
      end
      if (CMP_W'(on_nxt) >= CMP_W'(cfm_ticks)) qualified_nxt = 1'b1;
      ever_nxt = 1'b1;
      off_nxt  = '0;
    end else if (ever_r) begin
      off_nxt = off_inc;
      if (CMP_W'(off_inc) >= CMP_W'(rel_ticks)) begin
        qualified_nxt = 1'b0;
        run_nxt       = 1'b0;
        on_nxt        = '0;
      end
    end else begin
      qualified_nxt = 1'b0;
    end
  end

  // State registers, advanced once per transferred tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ever_r <= 1'b0;
      qual_r <= 1'b0;
      on_r   <= '0;
      off_r  <= '0;
    end else if (ctl.step) begin
      run_r  <= run_nxt;
      ever_r <= ever_nxt;
      qual_r <= qualified_nxt;
      on_r   <= on_nxt;
      off_r  <= off_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/debounced_priority_mode_select.sv
// Top level: debounced crosswalk/obstacle qualifiers and drive mode priority select.
//
// Usage:
//   Each input transfer (in_valid && in_ready) is one tick carrying the
//   crosswalk, red light and obstacle flags. Each tick yields exactly one
//   result transfer (out_valid && out_ready) with the drive mode, the two
//   qualified flags and a mode change flag.
//   Each result is registered and shown in the cycle after its tick transfer.
//   Throughput: one tick per cycle when not stalled; the qualifier counters,
//   threshold compares and the priority select all settle within that cycle.
//   in_ready is high whenever the output register is empty or being
//   drained, so a stalled receiver holds the result and blocks only new
//   ticks; nothing is dropped or repeated.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0..3:
//   crosswalk confirm, crosswalk release, obstacle confirm, obstacle
//   release). Other indexes are ignored. Write only while idle.
//   Reset (rst_n low, synchronous): counters and flags clear, the last mode
//   becomes lane, registers take their defaults, no result is pending.
`default_nettype none
module debounced_priority_mode_select #(
  parameter int COUNT_WIDTH = dpms_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [dpms_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [dpms_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_crosswalk_seen,
  input  wire logic                               in_red_light,
  input  wire logic                               in_obstacle_seen,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              out_drive_mode,
  output logic                                    out_crosswalk_confirmed,
  output logic                                    out_obstacle_confirmed,
  output logic                                    out_mode_changed
);
  import dpms_pkg::*;

  logic [CFG_WIDTH-1:0] cw_confirm_r, cw_release_r, ob_confirm_r, ob_release_r;
  logic                 in_xfer;
  chan_ctl_t            cw_ctl, ob_ctl;
  logic                 cw_qual_nxt, ob_qual_nxt;
  mode_t                mode_nxt, last_mode_r;
  logic                 out_valid_r;
  mode_t                mode_r;
  logic                 cw_q_r, ob_q_r, chg_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_confirm_r <= CW_CONFIRM_RST;
      cw_release_r <= CW_RELEASE_RST;
      ob_confirm_r <= OB_CONFIRM_RST;
      ob_release_r <= OB_RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CW_CONFIRM: cw_confirm_r <= cfg_wdata;
        REG_CW_RELEASE: cw_release_r <= cfg_wdata;
        REG_OB_CONFIRM: ob_confirm_r <= cfg_wdata;
        REG_OB_RELEASE: ob_release_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input handshake: take a tick unless a result is stuck in the output register
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign cw_ctl = '{step: in_xfer, seen: in_crosswalk_seen};
  assign ob_ctl = '{step: in_xfer, seen: in_obstacle_seen};

  dpms_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_cw (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (cw_ctl),
    .cfm_ticks     (cw_confirm_r),
    .rel_ticks     (cw_release_r),
    .qualified_nxt (cw_qual_nxt)
  );

  dpms_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_ob (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ob_ctl),
    .cfm_ticks     (ob_confirm_r),
    .rel_ticks     (ob_release_r),
    .qualified_nxt (ob_qual_nxt)
  );

  // Priority select
  always_comb begin
    priority if (cw_qual_nxt)  mode_nxt = MODE_CROSSWALK;
    else if (in_red_light)     mode_nxt = MODE_LIGHT;
    else if (ob_qual_nxt)      mode_nxt = MODE_OBSTACLE;
    else                       mode_nxt = MODE_LANE;
  end

  // Control: output valid and last mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_mode_r <= MODE_LANE;
    end else begin
      if (in_xfer) begin
        out_valid_r <= 1'b1;
        last_mode_r <= mode_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= mode_nxt;
      cw_q_r <= cw_qual_nxt;
      ob_q_r <= ob_qual_nxt;
      chg_r  <= (mode_nxt != last_mode_r);
    end
  end

  assign out_valid               = out_valid_r;
  assign out_drive_mode          = mode_r;
  assign out_crosswalk_confirmed = cw_q_r;
  assign out_obstacle_confirmed  = ob_q_r;
  assign out_mode_changed        = chg_r;

endmodule
`default_nettype wire

// File: hdl/dpms_checker.sv
// Port-level checker for debounced_priority_mode_select, with its bind.
`default_nettype none
module dpms_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_drive_mode,
  input wire logic       out_crosswalk_confirmed,
  input wire logic       out_obstacle_confirmed,
  input wire logic       out_mode_changed
);
  import dpms_pkg::*;

  // A transferred tick shows its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after tick transfer");

  // Input side is free whenever the output register can drain
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled without output back-pressure");

  // Confirmed crosswalk always wins the mode
  a_cw_priority: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crosswalk_confirmed |-> out_drive_mode == MODE_CROSSWALK)
    else $error("crosswalk confirmed but mode differs");

  // Obstacle mode needs a confirmed obstacle and no crosswalk
  a_ob_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_mode == MODE_OBSTACLE |->
      out_obstacle_confirmed && !out_crosswalk_confirmed)
    else $error("obstacle mode without qualified obstacle");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_mode)
      && $stable(out_mode_changed))
    else $error("stalled result changed");

endmodule

bind debounced_priority_mode_select dpms_checker u_dpms_checker (.*);
`default_nettype wire
